// File: hw/rtl/rhht_pkg.sv
// Package for the Robin Hood hash table unit: transaction structs, status codes
// and the controller/datapath command and status structs. No dependencies.
package rhht_pkg;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_NOT_FOUND = 2'd1;
   localparam logic [1:0] ST_FULL      = 2'd2;
   localparam logic [1:0] ST_INVALID   = 2'd3;

   localparam logic CMD_LOOKUP = 1'b0;
   localparam logic CMD_INSERT = 1'b1;

   typedef struct packed {
      logic        command;
      logic [31:0] key;
      logic [31:0] hash;
      logic [31:0] value;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] found_value;
      logic [9:0]  slot_index;
   } rsp_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic clear_step;  // write empty at clear index, advance it
      logic load;        // capture the request and set the probe start
      logic read;        // read the slot at the probe index
      logic write_carry; // write the carried entry at the probe index
      logic swap;        // carried entry takes the slot's old contents
      logic advance;     // next slot, distance plus one
      logic count_up;
   } ctl_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic clear_done;
      logic zero_hash;
      logic half_full;
      logic is_insert;
      logic slot_empty;
      logic slot_lower;  // stored distance below the carried one
      logic slot_match;
      logic wrapped;     // this probe is the last of a full wrap
   } sts_type;

endpackage

// File: hw/rtl/rhht_datapath.sv
// Datapath of the Robin Hood hash table: slot memories, carried entry, probe
// index and distance, entry count. Depends on rhht_pkg.
module rhht_datapath #(
   parameter int SLOTS = 1024
) (
   input  logic             clock,
   input  logic             reset,
   input  rhht_pkg::req_type req,
   input  rhht_pkg::ctl_type ctl,
   output rhht_pkg::sts_type sts,
   output logic [31:0]      rd_value,
   output logic [9:0]       probe_slot,
   output logic [9:0]       landed_slot
);
   localparam int AW = $clog2(SLOTS);

   logic [31:0] mem_key   [SLOTS];
   logic [31:0] mem_hash  [SLOTS];
   logic [31:0] mem_value [SLOTS];
   logic [AW-1:0] mem_dist [SLOTS];

   logic [31:0] rk_ff, rh_ff, rv_ff;
   logic [AW-1:0] rd_ff;
   logic [31:0] ck_ff, ch_ff, cv_ff;
   logic [AW:0] cd_ff;
   logic [AW-1:0] idx_ff, landed_ff;
   logic placed_ff, insert_ff;
   logic [AW:0] count_ff, clr_ff, probes_ff;

   logic [31:0] wk, wh, wv;
   logic [AW-1:0] wa, wd;
   logic we;

   always_comb begin
      we = ctl.clear_step | ctl.write_carry;
      wa = ctl.clear_step ? clr_ff[AW-1:0] : idx_ff;
      wk = ck_ff;
      wh = ctl.clear_step ? 32'd0 : ch_ff;
      wv = cv_ff;
      wd = cd_ff[AW-1:0];
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem_key[wa]   <= wk;
         mem_hash[wa]  <= wh;
         mem_value[wa] <= wv;
         mem_dist[wa]  <= wd;
      end
      if (ctl.read) begin
         rk_ff <= mem_key[idx_ff];
         rh_ff <= mem_hash[idx_ff];
         rv_ff <= mem_value[idx_ff];
         rd_ff <= mem_dist[idx_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff    <= '0;
         count_ff  <= '0;
         placed_ff <= 1'b0;
      end else begin
         if (ctl.clear_step) clr_ff <= clr_ff + 1'b1;
         if (ctl.count_up) count_ff <= count_ff + 1'b1;
         if (ctl.load) placed_ff <= 1'b0;
         else if (ctl.write_carry) placed_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         ck_ff     <= req.key;
         ch_ff     <= req.hash;
         cv_ff     <= req.value;
         cd_ff     <= '0;
         idx_ff    <= req.hash[AW-1:0];
         insert_ff <= req.command;
         probes_ff <= '0;
      end else begin
         if (ctl.write_carry && !placed_ff) landed_ff <= idx_ff;
         if (ctl.swap) begin
            ck_ff <= rk_ff;
            ch_ff <= rh_ff;
            cv_ff <= rv_ff;
         end
         if (ctl.advance) begin
            idx_ff    <= idx_ff + 1'b1;
            probes_ff <= probes_ff + 1'b1;
            cd_ff     <= (ctl.swap ? {1'b0, rd_ff} : cd_ff) + 1'b1;
         end
      end
   end

   always_comb begin
      sts.clear_done = clr_ff[AW];
      sts.zero_hash  = (req.hash == 32'd0);
      sts.half_full  = (count_ff >= (AW+1)'(SLOTS / 2));
      sts.is_insert  = insert_ff;
      sts.slot_empty = (rh_ff == 32'd0);
      sts.slot_lower = ({1'b0, rd_ff} < cd_ff);
      sts.slot_match = (rh_ff == ch_ff) && (rk_ff == ck_ff);
      sts.wrapped    = (probes_ff == (AW+1)'(SLOTS - 1));
      rd_value       = rv_ff;
      probe_slot     = 10'(idx_ff);
      landed_slot    = 10'(landed_ff);
   end
endmodule

// File: hw/rtl/rhht_control.sv
// Controller of the Robin Hood hash table: clearing pass, probe sequencing and
// result strobe. Depends on rhht_pkg.
module rhht_control (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic              cmd_insert,
   input  rhht_pkg::sts_type sts,
   input  logic [31:0]       rd_value,
   input  logic [9:0]        probe_slot,
   input  logic [9:0]        landed_slot,
   output logic              busy,
   output rhht_pkg::ctl_type ctl,
   output logic              rsp_valid,
   output rhht_pkg::rsp_type rsp
);
   localparam logic [2:0] S_CLEAR = 3'd0;
   localparam logic [2:0] S_IDLE  = 3'd1;
   localparam logic [2:0] S_READ  = 3'd2;
   localparam logic [2:0] S_EVAL  = 3'd3;
   localparam logic [2:0] S_DONE  = 3'd4;

   logic [2:0] state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   rhht_pkg::rsp_type rsp_ff, rsp_in;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      ctl          = '0;
      case (state_ff)
         S_CLEAR: begin
            if (sts.clear_done) state_in = S_IDLE;
            else ctl.clear_step = 1'b1;
         end
         S_IDLE: begin
            if (start) begin
               ctl.load = 1'b1;
               if (sts.zero_hash) begin
                  rsp_valid_in = 1'b1;
                  rsp_in = '{rhht_pkg::ST_INVALID, 32'd0, 10'd0};
               end else if (cmd_insert == rhht_pkg::CMD_INSERT && sts.half_full) begin
                  rsp_valid_in = 1'b1;
                  rsp_in = '{rhht_pkg::ST_FULL, 32'd0, 10'd0};
               end else begin
                  state_in = S_READ;
               end
            end
         end
         S_READ: begin
            ctl.read = 1'b1;
            state_in = S_EVAL;
         end
         S_EVAL: begin
            if (sts.is_insert) begin
               if (sts.slot_empty) begin
                  ctl.write_carry = 1'b1;
                  ctl.count_up    = 1'b1;
                  state_in        = S_DONE;
               end else begin
                  // A carried entry farther from its home slot takes the slot; probing continues.
                  if (sts.slot_lower) begin
                     ctl.write_carry = 1'b1;
                     ctl.swap        = 1'b1;
                  end
                  ctl.advance = 1'b1;
                  state_in    = S_READ;
               end
            end else begin
               if (sts.slot_empty || sts.slot_lower) begin
                  rsp_valid_in = 1'b1;
                  rsp_in = '{rhht_pkg::ST_NOT_FOUND, 32'd0, 10'd0};
                  state_in = S_IDLE;
               end else if (sts.slot_match) begin
                  rsp_valid_in = 1'b1;
                  rsp_in = '{rhht_pkg::ST_OK, rd_value, probe_slot};
                  state_in = S_IDLE;
               end else if (sts.wrapped) begin
                  rsp_valid_in = 1'b1;
                  rsp_in = '{rhht_pkg::ST_NOT_FOUND, 32'd0, 10'd0};
                  state_in = S_IDLE;
               end else begin
                  ctl.advance = 1'b1;
                  state_in    = S_READ;
               end
            end
         end
         S_DONE: begin
            rsp_valid_in = 1'b1;
            rsp_in = '{rhht_pkg::ST_OK, 32'd0, landed_slot};
            state_in = S_IDLE;
         end
         default: state_in = S_CLEAR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;
endmodule

// File: hw/rtl/robin_hood_hash_table_unit.sv
// Robin Hood hash table unit: top level joining controller and datapath.
// Depends on rhht_pkg, rhht_control and rhht_datapath.
//
// Usage: raise start with req_payload while busy is low; the transaction is
// taken at that edge. Exactly one result appears on rsp_payload with
// rsp_valid high for a single cycle. The receiver cannot stall it.
// A zero hash or a refused insert at half load answers in the cycle after
// acceptance. Otherwise each probed slot takes a registered memory read,
// then the compare and optional write on the single memory port; an insert
// issues its result from a done state after its final write.
// busy stays high until the result is issued; one operation at a time.
// After reset a clearing pass writes every slot empty, one slot per cycle,
// with busy high.
module robin_hood_hash_table_unit #(
   parameter int SLOTS = 1024
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  rhht_pkg::req_type req_payload,
   output logic              busy,
   output logic              rsp_valid,
   output rhht_pkg::rsp_type rsp_payload
);
   rhht_pkg::ctl_type ctl;
   rhht_pkg::sts_type sts;
   logic [31:0] rd_value;
   logic [9:0]  probe_slot, landed_slot;

   rhht_datapath #(.SLOTS(SLOTS)) u_dp (
      .clock, .reset, .req(req_payload), .ctl, .sts,
      .rd_value, .probe_slot, .landed_slot
   );

   rhht_control u_ctl (
      .clock, .reset, .start, .cmd_insert(req_payload.command), .sts,
      .rd_value, .probe_slot, .landed_slot, .busy, .ctl,
      .rsp_valid, .rsp(rsp_payload)
   );
endmodule

// File: hw/rtl/rhht_checker.sv
// Port-level checks for the Robin Hood hash table unit, bound to the top level.
// Depends on rhht_pkg.
module rhht_checker (
   input logic              clock,
   input logic              reset,
   input logic              start,
   input rhht_pkg::req_type req_payload,
   input logic              busy,
   input logic              rsp_valid,
   input rhht_pkg::rsp_type rsp_payload
);
   // A zero hash is answered as invalid in the next cycle.
   a_zero: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_payload.hash == 32'd0 |=>
      rsp_valid && rsp_payload.status == rhht_pkg::ST_INVALID)
      else $error("zero hash not flagged");

   // Any failed status carries zero value and slot.
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.status != rhht_pkg::ST_OK |->
      rsp_payload.found_value == 32'd0 && rsp_payload.slot_index == 10'd0)
      else $error("failure result not cleared");

   // A result needs either a transaction taken or an operation under way in the
   // cycle before.
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      !busy && !$past(busy) && !$past(start) |-> !rsp_valid)
      else $error("unexpected result");

   // Results are single cycle pulses unless a new transaction was taken
   // alongside the first one.
   a_pulse: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid || $past(start && !busy))
      else $error("result held too long");
endmodule

bind robin_hood_hash_table_unit rhht_checker u_rhht_checker (
   .clock, .reset, .start, .req_payload, .busy, .rsp_valid, .rsp_payload
);
